[sv/wpa_pkg.sv]
// ----------------------------------------------------------------------------
// wpa_pkg
// Shared types, constants and the control store for the windowed pose average.
// ----------------------------------------------------------------------------
`default_nettype none

package wpa_pkg;

  localparam int WL_W = 6;
  localparam logic [WL_W-1:0] WL_RESET = 6'd20;

  // divider lanes: x, y, qw, qx, qy, qz
  localparam int LANES = 6;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Q = 2;

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_WAIT     = 3'd0;
  localparam pc_t STEP_CHECK    = 3'd1;
  localparam pc_t STEP_REF      = 3'd2;
  localparam pc_t STEP_LOOP     = 3'd3;
  localparam pc_t STEP_DIV_GO   = 3'd4;
  localparam pc_t STEP_FEW      = 3'd5;
  localparam pc_t STEP_DIV_WAIT = 3'd6;
  localparam pc_t STEP_EMIT     = 3'd7;

  typedef enum logic [2:0] {
    JMP_NEXT      = 3'd0,
    JMP_ALWAYS    = 3'd1,
    JMP_NO_INPUT  = 3'd2,
    JMP_FEW       = 3'd3,
    JMP_LOOP_BUSY = 3'd4,
    JMP_DIV_BUSY  = 3'd5,
    JMP_OUT_FULL  = 3'd6
  } jmp_t;

  typedef struct packed {
    logic accept;      // take an input item, evict if window full
    logic rd_ref;      // read the oldest entry
    logic ref_load;    // capture reference quaternion
    logic loop_start;  // clear sums, start streaming the window
    logic div_start;
    logic emit;        // load result register, append new pose
    jmp_t jmp;
    pc_t  target;
  } uctl_t;

  typedef struct packed {
    logic in_valid;
    logic few;
    logic loop_busy;
    logic div_busy;
    logic out_full;
  } ustat_t;

  typedef struct packed {
    logic [31:0]      px;
    logic [31:0]      py;
    logic [3:0][15:0] q;   // q[0] = w
  } pose_t;

  function automatic uctl_t ucode(input pc_t pc);
    uctl_t w;
    w = uctl_t'('0);
    unique case (pc)
      STEP_WAIT: begin
        w.accept = 1'b1;
        w.jmp    = JMP_NO_INPUT;
        w.target = STEP_WAIT;
      end
      STEP_CHECK: begin
        w.rd_ref = 1'b1;
        w.jmp    = JMP_FEW;
        w.target = STEP_FEW;
      end
      STEP_REF: begin
        w.ref_load   = 1'b1;
        w.loop_start = 1'b1;
        w.jmp        = JMP_NEXT;
        w.target     = STEP_LOOP;
      end
      STEP_LOOP: begin
        w.jmp    = JMP_LOOP_BUSY;
        w.target = STEP_LOOP;
      end
      STEP_DIV_GO: begin
        w.div_start = 1'b1;
        w.jmp       = JMP_ALWAYS;
        w.target    = STEP_DIV_WAIT;
      end
      STEP_FEW: begin
        w.jmp    = JMP_ALWAYS;
        w.target = STEP_EMIT;
      end
      STEP_DIV_WAIT: begin
        w.jmp    = JMP_DIV_BUSY;
        w.target = STEP_DIV_WAIT;
      end
      STEP_EMIT: begin
        // falls through to step 0 by counter wrap
        w.emit   = 1'b1;
        w.jmp    = JMP_OUT_FULL;
        w.target = STEP_EMIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[sv/wpa_seq.sv]
// ----------------------------------------------------------------------------
// wpa_seq
// Step counter and control store; conditional jumps on datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module wpa_seq
  import wpa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  ustat_t stat,
  output uctl_t  ctl
);

  pc_t  pc;
  pc_t  pc_next;
  logic take;

  assign ctl = ucode(pc);

  always_comb begin
    unique case (ctl.jmp)
      JMP_NEXT:      take = 1'b0;
      JMP_ALWAYS:    take = 1'b1;
      JMP_NO_INPUT:  take = ~stat.in_valid;
      JMP_FEW:       take = stat.few;
      JMP_LOOP_BUSY: take = stat.loop_busy;
      JMP_DIV_BUSY:  take = stat.div_busy;
      JMP_OUT_FULL:  take = stat.out_full;
      default:       take = 1'b0;
    endcase
    pc_next = take ? ctl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

[sv/wpa_div.sv]
// ----------------------------------------------------------------------------
// wpa_div
// Six restoring divider lanes sharing one divisor, two quotient bits a cycle.
// Truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wpa_div
  import wpa_pkg::*;
#(
  parameter int CNT_W = 6,
  parameter int DIV_W = 38
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] dividend [LANES],
  input  logic [CNT_W-1:0]        divisor,
  output logic                    busy,
  output logic signed [DIV_W-1:0] quot [LANES]
);

  localparam int ITERS = DIV_W / 2;
  localparam int IT_W  = $clog2(ITERS + 1);

  logic [IT_W-1:0]  iter;
  logic [CNT_W-1:0] dv;
  logic [DIV_W-1:0] acc   [LANES];
  logic [DIV_W-1:0] acc_next [LANES];
  logic [CNT_W:0]   rem   [LANES];
  logic [CNT_W:0]   rem_next [LANES];
  logic             neg   [LANES];

  assign busy = (iter != '0);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_next[l] = rem[l];
      acc_next[l] = acc[l];
      for (int s = 0; s < 2; s++) begin
        rem_next[l] = {rem_next[l][CNT_W-1:0], acc_next[l][DIV_W-1]};
        acc_next[l] = {acc_next[l][DIV_W-2:0], 1'b0};
        if (rem_next[l] >= {1'b0, dv}) begin
          rem_next[l]    = rem_next[l] - {1'b0, dv};
          acc_next[l][0] = 1'b1;
        end
      end
      quot[l] = neg[l] ? (~acc[l] + 1'b1) : acc[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (start) begin
      iter <= IT_W'(ITERS);
    end else if (iter != '0) begin
      iter <= iter - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv <= divisor;
      for (int l = 0; l < LANES; l++) begin
        neg[l] <= dividend[l][DIV_W-1];
        acc[l] <= dividend[l][DIV_W-1] ? -dividend[l] : dividend[l];
        rem[l] <= '0;
      end
    end else if (iter != '0) begin
      for (int l = 0; l < LANES; l++) begin
        acc[l] <= acc_next[l];
        rem[l] <= rem_next[l];
      end
    end
  end

endmodule

`default_nettype wire

[sv/wpa_dp.sv]
// ----------------------------------------------------------------------------
// wpa_dp
// Datapath: pose ring memory, window bookkeeping, alignment and sum pipeline,
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wpa_dp
  import wpa_pkg::*;
#(
  parameter int MAX_WINDOW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  uctl_t              ctl,
  output ustat_t             stat,
  input  logic               cfg_wr_en,
  input  logic [WL_W-1:0]    cfg_wr_data,
  input  logic               in_valid,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic               div_busy,
  input  logic signed [32+$clog2(MAX_WINDOW+1)+($clog2(MAX_WINDOW+1)%2)-1:0] quot [LANES],
  output logic signed [32+$clog2(MAX_WINDOW+1)+($clog2(MAX_WINDOW+1)%2)-1:0] dividend [LANES],
  output logic [$clog2(MAX_WINDOW+1)-1:0] divisor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               avg_valid,
  output logic signed [31:0] avg_x,
  output logic signed [31:0] avg_y,
  output logic signed [15:0] avg_qw,
  output logic signed [15:0] avg_qx,
  output logic signed [15:0] avg_qy,
  output logic signed [15:0] avg_qz
);

  localparam int SW  = $clog2(MAX_WINDOW);
  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int PSW = 32 + CW;
  localparam int QSW = 17 + CW;
  localparam int DW  = 32 + CW + (CW % 2);
  localparam logic signed [DW-1:0] QMAX = DW'(32767);
  localparam logic signed [DW-1:0] QMIN = -DW'(32768);

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(MAX_WINDOW - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [DW-1:0] v);
    logic signed [15:0] r;
    if (v > QMAX) begin
      r = 16'sh7fff;
    end else if (v < QMIN) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic [WL_W-1:0] window_length;
  logic [CW-1:0]   count;
  logic [SW-1:0]   oldest;
  logic [CW-1:0]   win_eff;
  logic            evict;
  logic            accept_fire;
  logic            emit_fire;
  logic            few;
  logic            loop_busy;
  logic [SW:0]     wsum;
  logic [SW-1:0]   wslot;

  pose_t           new_pose;
  pose_t           store [MAX_WINDOW];
  pose_t           rd_q;
  logic [SW-1:0]   raddr;
  logic [3:0][15:0] ref_q;

  logic [SW-1:0]   rd_ptr;
  logic [CW-1:0]   left;
  logic            s1_valid;
  logic            s2_valid;
  logic signed [31:0] prod [4];
  logic [31:0]     px2;
  logic [31:0]     py2;
  logic [3:0][15:0] q2;
  logic signed [33:0] dot;
  logic signed [QSW-1:0] qt [4];
  logic signed [PSW-1:0] sx;
  logic signed [PSW-1:0] sy;
  logic signed [QSW-1:0] sq [4];

  // window register: zero acts as one, oversize clamps to the store depth
  always_comb begin
    if (window_length == '0) begin
      win_eff = CW'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      win_eff = CW'(MAX_WINDOW);
    end else begin
      win_eff = CW'(window_length);
    end
  end

  assign accept_fire = ctl.accept & in_valid;
  assign emit_fire   = ctl.emit & ~(out_valid & out_stall);
  assign evict       = (count >= win_eff) && (count != '0);
  assign few         = (count < CW'(2));
  assign loop_busy   = (left != '0) | s1_valid | s2_valid;

  // append slot is oldest + count, wrapped once
  assign wsum  = (SW+1)'(oldest) + (SW+1)'(count);
  assign wslot = (wsum >= (SW+1)'(MAX_WINDOW)) ? SW'(wsum - (SW+1)'(MAX_WINDOW))
                                               : wsum[SW-1:0];

  assign raddr = ctl.rd_ref ? oldest : rd_ptr;

  always_comb begin
    stat.in_valid  = in_valid;
    stat.few       = few;
    stat.loop_busy = loop_busy;
    stat.div_busy  = div_busy;
    stat.out_full  = out_valid & out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_RESET;
      count         <= '0;
      oldest        <= '0;
      left          <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
      end
      if (accept_fire && evict) begin
        count  <= count - 1'b1;
        oldest <= slot_inc(oldest);
      end else if (emit_fire) begin
        if (count < CW'(MAX_WINDOW)) begin
          count <= count + 1'b1;
        end else begin
          oldest <= slot_inc(oldest);
        end
      end
      if (ctl.loop_start) begin
        left <= count;
      end else if (left != '0) begin
        left <= left - 1'b1;
      end
      s1_valid <= (left != '0);
      s2_valid <= s1_valid;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pose ring
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      store[wslot] <= new_pose;
    end
    rd_q <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (accept_fire) begin
      new_pose.px <= pos_x;
      new_pose.py <= pos_y;
      new_pose.q  <= {quat_z, quat_y, quat_x, quat_w};
    end
    if (ctl.ref_load) begin
      ref_q <= rd_q.q;
    end
    if (ctl.loop_start) begin
      rd_ptr <= oldest;
    end else if (left != '0) begin
      rd_ptr <= slot_inc(rd_ptr);
    end
  end

  // stage 2: products against the reference quaternion
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      prod[i] <= $signed(rd_q.q[i]) * $signed(ref_q[i]);
    end
    px2 <= rd_q.px;
    py2 <= rd_q.py;
    q2  <= rd_q.q;
  end

  // stage 3: sign of the dot product picks the hemisphere, then accumulate
  always_comb begin
    dot = 34'(prod[0]) + 34'(prod[1]) + 34'(prod[2]) + 34'(prod[3]);
    for (int i = 0; i < 4; i++) begin
      qt[i] = dot[33] ? -QSW'($signed(q2[i])) : QSW'($signed(q2[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.loop_start) begin
      sx <= '0;
      sy <= '0;
      for (int i = 0; i < 4; i++) begin
        sq[i] <= '0;
      end
    end else if (s2_valid) begin
      sx <= sx + PSW'($signed(px2));
      sy <= sy + PSW'($signed(py2));
      for (int i = 0; i < 4; i++) begin
        sq[i] <= sq[i] + qt[i];
      end
    end
  end

  always_comb begin
    dividend[LANE_X] = DW'(sx);
    dividend[LANE_Y] = DW'(sy);
    for (int i = 0; i < 4; i++) begin
      dividend[LANE_Q+i] = DW'(sq[i]);
    end
  end

  assign divisor = count;

  // result register
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      avg_valid <= ~few;
      avg_x     <= few ? '0 : quot[LANE_X][31:0];
      avg_y     <= few ? '0 : quot[LANE_Y][31:0];
      avg_qw    <= few ? '0 : sat16(quot[LANE_Q]);
      avg_qx    <= few ? '0 : sat16(quot[LANE_Q+1]);
      avg_qy    <= few ? '0 : sat16(quot[LANE_Q+2]);
      avg_qz    <= few ? '0 : sat16(quot[LANE_Q+3]);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_WINDOW))
    else $error("stored count above store depth");

  a_sum_needs_two: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> !few)
    else $error("accumulating with fewer than two stored poses");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept_fire |-> (left == '0) && !s1_valid && !s2_valid && !div_busy)
    else $error("item taken while window pass or divide still running");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> out_valid)
    else $error("result loaded but not presented");
`endif

endmodule

`default_nettype wire

[sv/windowed_pose_average.sv]
// ----------------------------------------------------------------------------
// windowed_pose_average
// Sliding-window mean of planar poses with quaternion sign alignment.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  in       | in_valid / in_stall     | pos_x pos_y quat_w quat_x quat_y quat_z
//  out      | out_valid / out_stall   | avg_valid avg_x avg_y avg_qw..avg_qz
//  cfg      | cfg_wr_en (no wait)     | cfg_wr_data = window_length
//
//  One item at a time. With n poses left after eviction and n >= 2, the
//  block makes one ring-memory read per stored pose, then runs the shared
//  2-bit/cycle divider over DW-bit dividends (DW = 38 at MAX_WINDOW = 32).
//  Fewer than two stored poses: no divide, a zero result with avg_valid low.
//  in_stall is low only while the sequencer waits for an item; a stalled
//  result holds the block at the emit step. Synchronous reset, no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_pose_average
  import wpa_pkg::*;
#(
  parameter int MAX_WINDOW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [WL_W-1:0]    cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               avg_valid,
  output logic signed [31:0] avg_x,
  output logic signed [31:0] avg_y,
  output logic signed [15:0] avg_qw,
  output logic signed [15:0] avg_qx,
  output logic signed [15:0] avg_qy,
  output logic signed [15:0] avg_qz
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int DW = 32 + CW + (CW % 2);

  uctl_t  ctl;
  ustat_t stat;
  logic   div_busy;
  logic signed [DW-1:0] dividend [LANES];
  logic signed [DW-1:0] quot [LANES];
  logic [CW-1:0]        divisor;

  assign in_stall = ~ctl.accept;

  wpa_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  wpa_div #(
    .CNT_W (CW),
    .DIV_W (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quot     (quot)
  );

  wpa_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .quat_w      (quat_w),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z),
    .div_busy    (div_busy),
    .quot        (quot),
    .dividend    (dividend),
    .divisor     (divisor),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .avg_valid   (avg_valid),
    .avg_x       (avg_x),
    .avg_y       (avg_y),
    .avg_qw      (avg_qw),
    .avg_qx      (avg_qx),
    .avg_qy      (avg_qy),
    .avg_qz      (avg_qz)
  );

endmodule

`default_nettype wire
